[rtl/fbsa_pkg.sv]
// Shared types, widths and codes for the fixed-block free-stack allocator.
// No dependencies; every other file of the block imports this package.
package fbsa_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 17;
    localparam int SPAN_W     = CNT_W + SIZE_W;
    localparam int PROD_W     = IDX_W + SIZE_W;
    localparam int DVS_W      = SIZE_W + IDX_W - 1;
    localparam int STEP_W     = $clog2(IDX_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] free_address;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] block_address;
        logic [IDX_W-1:0]  block_number;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic check;
        logic mul;
        logic add;
        logic div_step;
        logic push;
        logic emit;
        logic cfg_we;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_free;
        logic empty;
        logic out_of_range;
        logic div_last;
    } t_sts;

    // Clamp a block count to the stack capacity
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] lim;
        lim = CNT_W'(MAX_BLOCKS);
        return (cnt > lim) ? lim : cnt;
    endfunction

endpackage

[rtl/fbsa_dp.sv]
// Datapath of the allocator: config registers, free stack memory, depth and
// low-water mark, range check, multiplier and restoring divider. Uses fbsa_pkg.
module fbsa_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fbsa_pkg::t_cmd                i_cmd,
    output fbsa_pkg::t_sts                o_sts,
    input  fbsa_pkg::t_req                i_req,
    input  logic [fbsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fbsa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output fbsa_pkg::t_rsp                o_rsp
);
    import fbsa_pkg::*;

    logic [ADDR_W-1:0] r_base;
    logic [SIZE_W-1:0] r_size;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_depth;
    logic [CNT_W-1:0]  r_low;
    logic [SPAN_W-1:0] r_span;
    t_req              r_req;

    logic [IDX_W-1:0]  mem [MAX_BLOCKS];
    logic [IDX_W-1:0]  r_rd;
    logic [IDX_W-1:0]  r_pos;
    logic              r_unw;

    logic [1:0]        r_status;
    logic [ADDR_W-1:0] r_baddr;
    logic [IDX_W-1:0]  r_bnum;
    logic [PROD_W-1:0] r_prod;
    logic [SPAN_W-1:0] r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [IDX_W-1:0]  r_q;
    logic [STEP_W-1:0] r_k;
    t_rsp              r_out;

    logic [SIZE_W-1:0] size_eff;
    logic [CNT_W-1:0]  count_eff;
    logic [CNT_W-1:0]  count_new;
    logic [ADDR_W:0]   diff;
    logic              oor;
    logic              empty;
    logic              full;
    logic [CNT_W-1:0]  pos;
    logic [IDX_W-1:0]  idx_pop;
    logic              do_pop;
    logic              do_push;
    logic              rem_ge;

    assign size_eff  = (r_size == '0) ? SIZE_W'(1) : r_size;
    assign count_eff = eff_count(r_count);
    assign count_new = (i_cfg_index == CFG_COUNT) ? eff_count(i_cfg_data[CNT_W-1:0])
                                                  : count_eff;
    assign diff      = {1'b0, r_req.free_address} - {1'b0, r_base};
    assign oor       = diff[ADDR_W] || (diff[ADDR_W-1:0] >= ADDR_W'(r_span));
    assign empty     = (r_depth == '0);
    assign full      = (r_depth >= count_eff);
    assign pos       = r_depth - CNT_W'(1);
    assign idx_pop   = r_unw ? r_pos : r_rd;
    assign do_pop    = i_cmd.check && (r_req.opcode == OP_ALLOC) && !empty;
    assign do_push   = i_cmd.push && !full;
    assign rem_ge    = (r_rem >= SPAN_W'(r_dvs));

    assign o_sts.is_free      = (r_req.opcode == OP_FREE);
    assign o_sts.empty        = empty;
    assign o_sts.out_of_range = oor;
    assign o_sts.div_last     = (r_k == '0);
    assign o_rsp              = r_out;

    // Config, depth and low-water mark. Entries below the low-water mark were
    // never written since the last refill and read back as their own index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_size  <= SIZE_W'(64);
            r_count <= CNT_W'(MAX_BLOCKS);
            r_depth <= CNT_W'(MAX_BLOCKS);
            r_low   <= CNT_W'(MAX_BLOCKS);
        end else if (i_cmd.cfg_we) begin
            case (i_cfg_index)
                CFG_BASE:  r_base  <= i_cfg_data[ADDR_W-1:0];
                CFG_SIZE:  r_size  <= i_cfg_data[SIZE_W-1:0];
                CFG_COUNT: r_count <= i_cfg_data[CNT_W-1:0];
                default:   ;
            endcase
            if (i_cfg_index inside {CFG_BASE, CFG_SIZE, CFG_COUNT}) begin
                r_depth <= count_new;
                r_low   <= count_new;
            end
        end else if (do_pop) begin
            r_depth <= pos;
            if (pos < r_low) begin
                r_low <= pos;
            end
        end else if (do_push) begin
            r_depth <= r_depth + CNT_W'(1);
        end
    end

    // Free stack memory, registered read at the current top
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_depth[IDX_W-1:0]] <= r_q;
        end
        r_rd <= mem[pos[IDX_W-1:0]];
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_span <= SPAN_W'(count_eff) * SPAN_W'(size_eff);
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.check) begin
            r_pos    <= pos[IDX_W-1:0];
            r_unw    <= (pos < r_low);
            r_baddr  <= '0;
            r_bnum   <= '0;
            if (r_req.opcode == OP_ALLOC) begin
                r_status <= empty ? ST_EMPTY : ST_OK;
            end else begin
                r_status <= oor ? ST_RANGE : ST_OK;
                if (!oor) begin
                    r_rem <= diff[SPAN_W-1:0];
                    r_dvs <= {size_eff, {(IDX_W-1){1'b0}}};
                    r_q   <= '0;
                    r_k   <= STEP_W'(IDX_W - 1);
                end
            end
        end
        if (i_cmd.mul) begin
            r_bnum <= idx_pop;
            r_prod <= PROD_W'(idx_pop) * PROD_W'(size_eff);
        end
        if (i_cmd.add) begin
            r_baddr <= r_base + ADDR_W'(r_prod);
        end
        if (i_cmd.div_step) begin
            if (rem_ge) begin
                r_rem <= r_rem - SPAN_W'(r_dvs);
            end
            r_q   <= {r_q[IDX_W-2:0], rem_ge};
            r_dvs <= r_dvs >> 1;
            r_k   <= r_k - STEP_W'(1);
        end
        if (i_cmd.push) begin
            r_bnum   <= r_q;
            r_status <= full ? ST_FULL : ST_OK;
        end
        if (i_cmd.emit) begin
            r_out.status        <= r_status;
            r_out.block_address <= r_baddr;
            r_out.block_number  <= r_bnum;
        end
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= count_eff)
        else $error("free depth above block count");

    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_depth)
        else $error("low-water mark above free depth");

    a_pop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop |=> (r_depth == $past(r_depth) - CNT_W'(1)))
        else $error("pop did not lower depth by one");

endmodule

[rtl/fbsa_ctrl.sv]
// Controller state machine of the allocator: handshakes and sequencing of
// check, multiply, add, divide and push steps. Uses fbsa_pkg.
module fbsa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  fbsa_pkg::t_sts i_sts,
    output fbsa_pkg::t_cmd o_cmd
);
    import fbsa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.load     = i_in_valid && o_in_ready;
        o_cmd.cfg_we   = i_cfg_valid && o_cfg_ready;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_sts.is_free) begin
                    n_state = i_sts.out_of_range ? S_FIN : S_DIV;
                end else begin
                    n_state = i_sts.empty ? S_FIN : S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_FIN;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> out_free)
        else $error("result register overwritten");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_cmd.load && !o_cmd.cfg_we)
        else $error("transfer taken while busy");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> o_out_valid && (r_state == S_IDLE))
        else $error("emitted result not presented");

endmodule

[rtl/fixed_block_free_stack_allocator.sv]
// Top level of the fixed-size block pool allocator with a LIFO free stack.
// Instantiates fbsa_ctrl and fbsa_dp; types and codes come from fbsa_pkg.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------
//   in      | input     | i_in_valid / o_in_ready  | i_in_data  (t_req)
//   out     | output    | o_out_valid / i_out_ready| o_out_data (t_rsp)
//   cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// An allocate runs check, one memory read, one 27-bit multiply and one add;
// an empty pool goes to the result after the check. A free runs check,
// 10 restoring-divide steps set by the index width, and push; a range miss
// goes to the result after the check. One item is in work at a time.
// Reset is synchronous: base 0, block size 64, count 1024, stack full; no
// clearing pass is needed since a low-water mark tracks untouched entries.
// A stalled output holds the finished result; the next item may enter.
module fixed_block_free_stack_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  fbsa_pkg::t_req                  i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output fbsa_pkg::t_rsp                  o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fbsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fbsa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fbsa_pkg::*;

    // Command and status between the controller and the datapath
    t_cmd cmd;
    t_sts sts;

    fbsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Stack, config registers and arithmetic; result register at the output
    fbsa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_in_data),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_rsp       (o_out_data)
    );

endmodule
